// ----- hw/rtl/home_status_frame_builder_core_assert.svh -----
// Assertion macros for the status frame builder checker.
// Included by the checker file only; no other dependencies.
`ifndef HOME_STATUS_FRAME_BUILDER_CORE_ASSERT_SVH
`define HOME_STATUS_FRAME_BUILDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define HSFB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted
`define HSFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication that also holds across reset
`define HSFB_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ----- hw/rtl/hsfb_pkg.sv -----
// Shared types and constants for the status frame builder.
// No dependencies; imported by every RTL module of the block.
package hsfb_pkg;

    typedef logic [7:0] t_byte;

    // One classified tick: twelve flag hits and the buzzer latch after it
    typedef struct packed {
        logic [11:0] flags;
        logic        buzz;
    } t_rec;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_RELAY_ONE   = 3'd0,
        CFG_RELAY_TWO   = 3'd1,
        CFG_RELAY_THREE = 3'd2,
        CFG_RELAY_FOUR  = 3'd3,
        CFG_SETPOINT    = 3'd4,
        CFG_ARMED       = 3'd5
    } t_cfg_idx;

    localparam int    CFG_DATA_W      = 34;
    localparam int    TIME_W          = 17;
    localparam int    NUM_RELAYS      = 4;
    localparam int    NUM_FLAGS       = 12;
    localparam int    FRAME_LEN       = 14;
    localparam t_byte FRAME_HEADER    = 8'hFF;
    localparam t_byte ASCII_ZERO      = 8'h30;
    localparam logic [7:0] SETPOINT_RST = 8'd25;

    // Thresholds on 10-bit converter samples
    localparam logic [9:0] OUTSIDE_DARK_MAX  = 10'd306;
    localparam logic [9:0] INSIDE_BRIGHT_MIN = 10'd512;
    localparam logic [9:0] LASER_BLOCK_MAX   = 10'd613;

    // Divide by ten as multiply by 205 and shift by 11, exact for 0..1023
    localparam logic [7:0] TEMP_RECIP       = 8'd205;
    localparam int         TEMP_RECIP_SHIFT = 11;

    // ASCII code sent for each flag when it is set, frame bytes 1..12
    localparam t_byte FLAG_CODE [NUM_FLAGS] = '{
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h31, 8'h32, 8'h33
    };

endpackage

// ----- hw/rtl/hsfb_front.sv -----
// Front end: configuration registers, tick acceptance and flag classification.
// Depends on hsfb_pkg; feeds hsfb_queue.
module hsfb_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [2:0]                         i_cfg_index,
    input  logic [hsfb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_push,
    input  logic [4:0]                         i_clock_hour,
    input  logic [5:0]                         i_clock_minute,
    input  logic [5:0]                         i_clock_second,
    input  logic [9:0]                         i_temp_sample,
    input  logic [9:0]                         i_outside_light,
    input  logic [9:0]                         i_inside_light,
    input  logic [9:0]                         i_laser_light,
    output hsfb_pkg::t_rec                     o_rec
);
    import hsfb_pkg::*;

    logic [CFG_DATA_W-1:0] r_window [NUM_RELAYS];
    logic [7:0]            r_setpoint;
    logic                  r_armed;
    logic                  r_buzz;
    logic                  n_buzz;

    logic [TIME_W-1:0]     now;
    logic [17:0]           temp_prod;
    logic [6:0]            temp_whole;
    logic signed [7:0]     whole_s;
    logic signed [7:0]     sp_s;
    logic [11:0]           flags;

    // Hold configuration; the user must write only while the block is idle, not enforced here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_RELAYS; k++) begin
                r_window[k] <= '0;
            end
            r_setpoint <= SETPOINT_RST;
            r_armed    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RELAY_ONE:   r_window[0] <= i_cfg_data;
                CFG_RELAY_TWO:   r_window[1] <= i_cfg_data;
                CFG_RELAY_THREE: r_window[2] <= i_cfg_data;
                CFG_RELAY_FOUR:  r_window[3] <= i_cfg_data;
                CFG_SETPOINT:    r_setpoint  <= i_cfg_data[7:0];
                CFG_ARMED:       r_armed     <= i_cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Classify the tick: relay time matches, temperature, light levels
    always_comb begin
        now       = {i_clock_hour, i_clock_minute, i_clock_second};
        temp_prod = 18'(i_temp_sample) * 18'(TEMP_RECIP);
        temp_whole = temp_prod[17:TEMP_RECIP_SHIFT];
        whole_s   = signed'({1'b0, temp_whole});
        sp_s      = signed'(r_setpoint);
        for (int k = 0; k < NUM_RELAYS; k++) begin
            flags[2*k]   = (now == r_window[k][TIME_W-1:0]);
            flags[2*k+1] = (now == r_window[k][2*TIME_W-1:TIME_W]);
        end
        flags[8]  = (sp_s < whole_s);
        flags[9]  = (sp_s > whole_s);
        flags[10] = (i_outside_light <= OUTSIDE_DARK_MAX);
        flags[11] = (i_inside_light >= INSIDE_BRIGHT_MIN);
    end

    // Update buzzer latch: clear when disarmed, set on a broken beam
    always_comb begin
        n_buzz = r_buzz;
        if (!r_armed) begin
            n_buzz = 1'b0;
        end else if (i_laser_light <= LASER_BLOCK_MAX) begin
            n_buzz = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buzz <= 1'b0;
        end else if (i_push) begin
            r_buzz <= n_buzz;
        end
    end

    assign o_rec.flags = flags;
    assign o_rec.buzz  = n_buzz;

endmodule

// ----- hw/rtl/hsfb_queue.sv -----
// Short FIFO of classified ticks between front and back ends.
// Depends on hsfb_pkg for the record type.
module hsfb_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hsfb_pkg::t_rec i_rec,
    input  logic           i_pop,
    output hsfb_pkg::t_rec o_rec,
    output logic           o_full,
    output logic           o_empty
);
    import hsfb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rec   = r_mem[r_rd];

    // Store pushed records
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/hsfb_back.sv -----
// Back end: serializes one record into a fourteen-byte frame with checksum.
// Depends on hsfb_pkg; drains hsfb_queue and drives the output channel.
module hsfb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  hsfb_pkg::t_rec i_q_rec,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_frame_byte,
    output logic           o_frame_end,
    output logic           o_buzzer_on
);
    import hsfb_pkg::*;

    localparam logic [3:0] IDX_LAST = 4'(FRAME_LEN - 1);

    t_rec       r_rec;
    logic       r_busy;
    logic [3:0] r_idx;
    logic [7:0] r_sum;
    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_end;
    logic       r_buzz;

    logic       adv;
    logic       last;
    logic [3:0] flag_idx;
    t_byte      cur_byte;

    // Output register moves when empty or taken
    assign adv   = !r_ov || !i_stall;
    assign last  = r_busy && (r_idx == IDX_LAST);
    assign o_pop = !i_q_empty && (!r_busy || (adv && last));

    // Select the byte at the current frame position
    always_comb begin
        flag_idx = r_idx - 4'd1;
        if (r_idx == '0) begin
            cur_byte = FRAME_HEADER;
        end else if (r_idx == IDX_LAST) begin
            cur_byte = r_sum;
        end else if (r_rec.flags[flag_idx]) begin
            cur_byte = FLAG_CODE[flag_idx];
        end else begin
            cur_byte = ASCII_ZERO;
        end
    end

    // Step through the frame and load the next record on the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (adv) begin
                r_ov <= r_busy;
                if (r_busy) begin
                    r_byte <= cur_byte;
                    r_end  <= last;
                    r_buzz <= r_rec.buzz;
                    r_sum  <= (r_idx == '0) ? '0 : r_sum + cur_byte;
                    r_idx  <= r_idx + 4'd1;
                end
            end
            if (o_pop) begin
                r_rec  <= i_q_rec;
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (adv && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_valid      = r_ov;
    assign o_frame_byte = r_byte;
    assign o_frame_end  = r_end;
    assign o_buzzer_on  = r_buzz;

endmodule

// ----- hw/rtl/home_status_frame_builder_core.sv -----
// Top level of the status frame builder: front end, record queue, back end.
// Depends on hsfb_pkg, hsfb_front, hsfb_queue and hsfb_back.
//
//  channel   handshake                   payload
//  -------   -------------------------   --------------------------------------
//  tick in   i_valid / o_stall           clock hour, minute, second, four samples
//  frame out o_valid / i_stall           frame byte, frame end, buzzer state
//  config    i_cfg_valid / o_cfg_ready   register index (3 bits), data (34 bits)
//
// Each tick produces fourteen bytes, one per cycle from the back end's output
// register while the output does not stall. The front end classifies a tick in
// the cycle it is accepted; the queue holds P_QUEUE_DEPTH classified ticks, so
// input stalls only when the queue is full. Reset is synchronous, active low; it
// restores register defaults and clears the buzzer latch. Output stall holds the
// current byte and pauses the frame.
module home_status_frame_builder_core #(
    parameter int P_QUEUE_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [4:0]                      i_clock_hour,
    input  logic [5:0]                      i_clock_minute,
    input  logic [5:0]                      i_clock_second,
    input  logic [9:0]                      i_temp_sample,
    input  logic [9:0]                      i_outside_light,
    input  logic [9:0]                      i_inside_light,
    input  logic [9:0]                      i_laser_light,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [7:0]                      o_frame_byte,
    output logic                            o_frame_end,
    output logic                            o_buzzer_on,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [2:0]                      i_cfg_index,
    input  logic [hsfb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hsfb_pkg::*;

    t_rec front_rec;
    t_rec q_rec;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    // Accept a tick whenever the queue has room
    assign o_stall     = q_full;
    assign push        = i_valid && !q_full;
    assign o_cfg_ready = 1'b1;

    hsfb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_push          (push),
        .i_clock_hour    (i_clock_hour),
        .i_clock_minute  (i_clock_minute),
        .i_clock_second  (i_clock_second),
        .i_temp_sample   (i_temp_sample),
        .i_outside_light (i_outside_light),
        .i_inside_light  (i_inside_light),
        .i_laser_light   (i_laser_light),
        .o_rec           (front_rec)
    );

    hsfb_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_rec   (q_rec),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    hsfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_rec      (q_rec),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_byte (o_frame_byte),
        .o_frame_end  (o_frame_end),
        .o_buzzer_on  (o_buzzer_on)
    );

endmodule

// ----- hw/rtl/hsfb_checker.sv -----
// Port-level checker for the status frame builder, bound to the top level.
// Depends on home_status_frame_builder_core_assert.svh and hsfb_pkg.
`include "home_status_frame_builder_core_assert.svh"

module hsfb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_frame_byte,
    input logic       o_frame_end,
    input logic       o_buzzer_on
);
    import hsfb_pkg::*;

    logic out_wait;
    logic out_xfer;
    logic mid_xfer;
    logic hdr_seen;

    // Output channel events
    assign out_wait = o_valid && i_stall;
    assign out_xfer = o_valid && !i_stall;
    assign mid_xfer = out_xfer && !o_frame_end;
    assign hdr_seen = (o_frame_byte == FRAME_HEADER) && !o_frame_end;

    // Output is empty right after reset
    `HSFB_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_valid)

    // Stalled output holds its byte and frame end
    `HSFB_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_wait, o_valid && $stable(o_frame_byte))
    `HSFB_ASSERT_NEXT(a_hold_end, i_clk, i_rst_n, out_wait, $stable(o_frame_end))

    // A byte shown right after a frame's last transfer opens a new frame
    `HSFB_ASSERT_NEXT(a_header, i_clk, i_rst_n, out_xfer && o_frame_end, !o_valid || hdr_seen)

    // Buzzer state is constant within a frame
    `HSFB_ASSERT_NEXT(a_buzz, i_clk, i_rst_n, mid_xfer, !o_valid || $stable(o_buzzer_on))

endmodule

bind home_status_frame_builder_core hsfb_checker u_hsfb_checker (.*);
